// File: design/voice_allocator_generational_handles_core_assert.svh
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared assertion shorthands, clocked on aclk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef VOICE_ALLOCATOR_GENERATIONAL_HANDLES_CORE_ASSERT_SVH
`define VOICE_ALLOCATOR_GENERATIONAL_HANDLES_CORE_ASSERT_SVH

// same-cycle implication
`define VAGH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VAGH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/vagh_pkg.sv
// ----------------------------------------------------------------------------
// vagh_pkg
// Item types, command codes and cell-row types of the voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package vagh_pkg;

    localparam int IDX_W = 8;
    localparam int GEN_W = 24;
    localparam int AGE_W = 64;
    localparam int BID_W = 32;
    localparam int HDL_W = 32;

    localparam logic [GEN_W-1:0] GEN_MASK = 24'hFF_FFFF;

    // input commands
    localparam logic [1:0] CMD_PLAY   = 2'd0;
    localparam logic [1:0] CMD_STOP   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_BACKEND_AVAILABLE = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_ENABLED    = 2'd1;
    localparam logic [1:0] CFG_OUTPUT_PAUSED     = 2'd2;
    localparam logic [1:0] CFG_USER_UNLOCKED     = 2'd3;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [HDL_W-1:0] voice_handle_in;
        logic [4:0]       slot_number;
        logic             request_valid;
        logic [BID_W-1:0] new_backend_id;
    } vagh_in_t;

    typedef struct packed {
        logic [HDL_W-1:0] voice_handle_out;
        logic             handle_live;
        logic [BID_W-1:0] live_backend_id;
        logic             release_valid;
        logic [BID_W-1:0] release_backend_id;
    } vagh_out_t;

    // operation broadcast to every cell for one pass down the row
    typedef enum logic [2:0] {
        OP_SEARCH,
        OP_COMMIT,
        OP_STOP,
        OP_FINISH,
        OP_QUERY
    } pass_op_t;

    typedef struct packed {
        pass_op_t         op;
        logic [IDX_W-1:0] tgt;
        logic [GEN_W-1:0] gen;
        logic [BID_W-1:0] backend;
        logic [AGE_W-1:0] age;
    } cell_cmd_t;

    // record handed from cell to cell
    typedef struct packed {
        logic             tok;
        logic             found_free;
        logic [IDX_W-1:0] best_idx;
        logic [AGE_W-1:0] best_age;
        logic             live;
        logic [BID_W-1:0] live_id;
        logic             rel;
        logic [BID_W-1:0] rel_id;
        logic [HDL_W-1:0] h_out;
    } chain_rec_t;

    // next generation, never 0
    function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        n = (g + 24'd1) & GEN_MASK;
        return (n == '0) ? 24'd1 : n;
    endfunction

endpackage

`default_nettype wire

// File: design/vagh_cell.sv
// ----------------------------------------------------------------------------
// vagh_cell
// One voice slot: holds its state and merges it into the passing record.
// ----------------------------------------------------------------------------
`default_nettype none

module vagh_cell
    import vagh_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IDX_W-1:0] cell_idx,
    input  wire cell_cmd_t        cmd,
    input  wire chain_rec_t       rec_in,
    output chain_rec_t            rec_out
);

    logic             occ_reg,     occ_next;
    logic [GEN_W-1:0] gen_reg,     gen_next;
    logic [BID_W-1:0] backend_reg, backend_next;
    logic [AGE_W-1:0] age_reg,     age_next;
    logic             tok_reg;
    chain_rec_t       rec_reg,     rec_next;

    logic             hit;
    logic             hmatch;
    logic [GEN_W-1:0] gen_bumped;
    logic [GEN_W-1:0] gen_after;

    assign hit        = rec_in.tok && (cmd.tgt == cell_idx);
    assign hmatch     = hit && occ_reg && (gen_reg == cmd.gen);
    assign gen_bumped = bump_gen(gen_reg);
    assign gen_after  = occ_reg ? gen_bumped : gen_reg;

    always_comb begin
        occ_next     = occ_reg;
        gen_next     = gen_reg;
        backend_next = backend_reg;
        age_next     = age_reg;
        rec_next     = rec_in;
        case (cmd.op)
            OP_SEARCH: begin
                if (!rec_in.found_free) begin
                    if (!occ_reg) begin
                        rec_next.found_free = 1'b1;
                        rec_next.best_idx   = cell_idx;
                    end else if (cell_idx == '0 || age_reg < rec_in.best_age) begin
                        rec_next.best_idx = cell_idx;
                        rec_next.best_age = age_reg;
                    end
                end
            end
            OP_COMMIT: begin
                if (hit) begin
                    // steal first if the slot is busy, then take it unless the new backend id is zero
                    if (occ_reg) begin
                        rec_next.rel    = 1'b1;
                        rec_next.rel_id = backend_reg;
                        occ_next        = 1'b0;
                        gen_next        = gen_bumped;
                    end
                    if (cmd.backend != '0) begin
                        occ_next       = 1'b1;
                        backend_next   = cmd.backend;
                        age_next       = cmd.age;
                        rec_next.h_out = {gen_after, cell_idx + 8'd1};
                    end
                end
            end
            OP_STOP: begin
                if (hmatch) begin
                    rec_next.live   = 1'b1;
                    rec_next.rel    = 1'b1;
                    rec_next.rel_id = backend_reg;
                    occ_next        = 1'b0;
                    gen_next        = gen_bumped;
                end
            end
            OP_FINISH: begin
                if (hit && occ_reg) begin
                    rec_next.rel    = 1'b1;
                    rec_next.rel_id = backend_reg;
                    occ_next        = 1'b0;
                    gen_next        = gen_bumped;
                end
            end
            OP_QUERY: begin
                if (hmatch) begin
                    rec_next.live    = 1'b1;
                    rec_next.live_id = backend_reg;
                end
            end
            default: begin
                rec_next = rec_in;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
            gen_reg <= 24'd1;
            tok_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            gen_reg <= gen_next;
            tok_reg <= rec_in.tok;
        end
    end

    always_ff @(posedge aclk) begin
        backend_reg <= backend_next;
        age_reg     <= age_next;
        rec_reg     <= rec_next;
    end

    always_comb begin
        rec_out     = rec_reg;
        rec_out.tok = tok_reg;
    end

endmodule

`default_nettype wire

// File: design/voice_allocator_generational_handles_core.sv
// ----------------------------------------------------------------------------
// Voice allocator with generational handles
// Row of voice-slot cells with a small pass sequencer in front.
// ----------------------------------------------------------------------------
// One item in flight at a time. A record walks the row of VOICE_SLOTS cells,
// one cell per clock. Stop, finish and query items make one pass down the
// row; an accepted play runs a search pass and then a commit pass; a refused
// play skips the row and goes straight to ST_HOLD. A finished result waits in
// ST_HOLD and moves to the output register at the first edge where that
// register is free; s_ready returns at that same edge, even if m_ready is
// still low, so the next item can start while the last result waits. If an
// older result is still waiting when the next one finishes, the new one stays
// in ST_HOLD and s_ready stays low until the older one is taken. Handles are
// {generation[23:0], index+1}; configuration writes are taken at any time but
// belong only in idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_allocator_generational_handles_core
    import vagh_pkg::*;
#(
    parameter int VOICE_SLOTS = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire vagh_in_t   s_data,

    output logic            m_valid,
    input  wire logic       m_ready,
    output vagh_out_t       m_data,

    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_idx,
    input  wire logic [0:0] cfg_data
);

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_RUN    = 4'b0100,
        ST_HOLD   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic             start_reg, start_next;
    cell_cmd_t        cmd_reg,   cmd_next;
    logic [AGE_W-1:0] age_cnt_reg, age_cnt_next;
    vagh_out_t        res_reg,   res_next;
    logic             m_valid_reg, m_valid_next;
    vagh_out_t        m_data_reg,  m_data_next;

    // configuration
    logic backend_available_reg;
    logic output_enabled_reg;
    logic output_paused_reg;
    logic user_unlocked_reg;
    logic play_ok;

    // cell row: rec[0] is the head, rec[VOICE_SLOTS] the tail
    chain_rec_t rec [VOICE_SLOTS+1];
    cell_cmd_t  cmd_bus;

    assign play_ok = backend_available_reg && output_enabled_reg &&
                     !output_paused_reg && user_unlocked_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            backend_available_reg <= 1'b1;
            output_enabled_reg    <= 1'b1;
            output_paused_reg     <= 1'b0;
            user_unlocked_reg     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_BACKEND_AVAILABLE: backend_available_reg <= cfg_data[0];
                CFG_OUTPUT_ENABLED:    output_enabled_reg    <= cfg_data[0];
                CFG_OUTPUT_PAUSED:     output_paused_reg     <= cfg_data[0];
                CFG_USER_UNLOCKED:     user_unlocked_reg     <= cfg_data[0];
                default:               user_unlocked_reg     <= user_unlocked_reg;
            endcase
        end
    end

    // head record: fresh token, empty result, no candidate yet
    always_comb begin
        rec[0]     = '0;
        rec[0].tok = start_reg;
    end

    // the stamp for a commit is the next age serial
    always_comb begin
        cmd_bus     = cmd_reg;
        cmd_bus.age = age_cnt_reg + 64'd1;
    end

    for (genvar i = 0; i < VOICE_SLOTS; i++) begin : g_cell
        vagh_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(i)),
            .cmd      (cmd_bus),
            .rec_in   (rec[i]),
            .rec_out  (rec[i+1])
        );
    end

    always_comb begin
        state_next   = state_reg;
        start_next   = 1'b0;
        cmd_next     = cmd_reg;
        age_cnt_next = age_cnt_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next.backend = s_data.new_backend_id;
                    cmd_next.gen     = s_data.voice_handle_in[HDL_W-1:IDX_W];
                    // index field minus one; a zero field lands on 255, no cell
                    cmd_next.tgt     = s_data.voice_handle_in[IDX_W-1:0] - 8'd1;
                    case (s_data.cmd)
                        CMD_PLAY: begin
                            if (play_ok && s_data.request_valid) begin
                                cmd_next.op = OP_SEARCH;
                                start_next  = 1'b1;
                                state_next  = ST_SEARCH;
                            end else begin
                                res_next   = '0;
                                state_next = ST_HOLD;
                            end
                        end
                        CMD_STOP: begin
                            cmd_next.op = OP_STOP;
                            start_next  = 1'b1;
                            state_next  = ST_RUN;
                        end
                        CMD_FINISH: begin
                            cmd_next.op  = OP_FINISH;
                            cmd_next.tgt = {3'b000, s_data.slot_number};
                            start_next   = 1'b1;
                            state_next   = ST_RUN;
                        end
                        default: begin
                            cmd_next.op = OP_QUERY;
                            start_next  = 1'b1;
                            state_next  = ST_RUN;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // free slot or oldest voice found: commit to it on a second pass
                if (rec[VOICE_SLOTS].tok) begin
                    cmd_next.op  = OP_COMMIT;
                    cmd_next.tgt = rec[VOICE_SLOTS].best_idx;
                    start_next   = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN: begin
                if (rec[VOICE_SLOTS].tok) begin
                    res_next.voice_handle_out   = rec[VOICE_SLOTS].h_out;
                    res_next.handle_live        = rec[VOICE_SLOTS].live;
                    res_next.live_backend_id    = rec[VOICE_SLOTS].live_id;
                    res_next.release_valid      = rec[VOICE_SLOTS].rel;
                    res_next.release_backend_id = rec[VOICE_SLOTS].rel_id;
                    if (cmd_reg.op == OP_COMMIT && cmd_reg.backend != '0) begin
                        age_cnt_next = age_cnt_reg + 64'd1;
                    end
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            age_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            age_cnt_reg <= age_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: design/vagh_checker.sv
// ----------------------------------------------------------------------------
// vagh_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voice_allocator_generational_handles_core_assert.svh"

module vagh_checker
    import vagh_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire vagh_out_t m_data
);

    `VAGH_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `VAGH_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "second item taken while one is in flight")
    `VAGH_ASSERT_IMPL(a_handle_form, m_valid && m_data.voice_handle_out != 32'd0, m_data.voice_handle_out[7:0] != 8'd0 && m_data.voice_handle_out[31:8] != 24'd0, "issued handle has zero index or generation")
    `VAGH_ASSERT_IMPL(a_rel_id, m_valid && !m_data.release_valid, m_data.release_backend_id == 32'd0, "release id without release")
    `VAGH_ASSERT_IMPL(a_live_id, m_valid && !m_data.handle_live, m_data.live_backend_id == 32'd0, "live id reported for dead handle")

endmodule

bind voice_allocator_generational_handles_core vagh_checker u_vagh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
